>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the fan step table checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while the reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// A signal must hold its value in the cycle after a condition.
`define ASSERT_STABLE_WHEN(label, clk, rst_n, cond, sig, msg) \
  `ASSERT_CLK(label, clk, rst_n, (cond) |=> $stable(sig), msg)

`endif

>>> rtl/core/fsth_pkg.sv
// ---------------------------------------------------------------------------
// fsth_pkg
// Types, field layout and defaults of the fan step table block.
// ---------------------------------------------------------------------------
`default_nettype none

package fsth_pkg;

  localparam int LEVELS_DEF       = 8;
  localparam int FAN_CHANNELS_DEF = 2;

  localparam int TEMP_W   = 10;
  localparam int LVL_IN_W = 3;
  localparam int RPM_W    = 16;

  // Slave tdata layout, lowest bit first.
  localparam int CHIP_BIT  = 0;
  localparam int TBL_BIT   = 1;
  localparam int FAN_BIT   = 2;
  localparam int TEMP_LSB  = 3;
  localparam int LVL_LSB   = TEMP_LSB + TEMP_W;
  localparam int ON_LSB    = LVL_LSB + LVL_IN_W;
  localparam int OFF_LSB   = ON_LSB + TEMP_W;
  localparam int RPM_LSB   = OFF_LSB + TEMP_W;
  localparam int S_USED_W  = RPM_LSB + RPM_W;
  localparam int S_TDATA_W = ((S_USED_W + 7) / 8) * 8;
  localparam int S_TUSER_W = 1;
  localparam int FUNC_BIT  = 0;

  // Master tdata layout: channel in bit 0, rpm target above it.
  localparam int M_USED_W  = 1 + RPM_W;
  localparam int M_TDATA_W = ((M_USED_W + 7) / 8) * 8;
  localparam int M_PAD_W   = M_TDATA_W - M_USED_W;

  typedef enum logic {
    FUNC_SAMPLE = 1'b0,
    FUNC_WRITE  = 1'b1
  } func_e;

  typedef struct packed {
    logic lt;
    logic eq;
    logic gt;
  } cmp_res_t;

endpackage

`default_nettype wire

>>> rtl/core/fan_step_table_hysteresis.sv
// ---------------------------------------------------------------------------
// fan_step_table_hysteresis
// Fan level selector with hysteresis over a clamshell and a tablet table.
// ---------------------------------------------------------------------------
// A table write (tuser = 1) loads one level of one table in the cycle it is
// accepted and gives no result. A temperature sample with the chipset on
// walks the fan level through the points memory, one level per visit, using
// a single shared comparator; each visited level takes a memory read state
// and then a compare state, and the slave side stays busy until the sample
// is done. A rising walk visits at most LEVELS levels and a falling walk at
// most LEVELS - 1. The rpm target of the final level is read from the rpm
// memory and placed in an output register, and the next transaction is
// taken while it waits there; a sample that finishes while the previous
// result is still waiting holds until that result is taken. Samples with
// the chipset off are accepted without leaving idle and give no result.
`default_nettype none

module fan_step_table_hysteresis #(
  parameter int LEVELS       = fsth_pkg::LEVELS_DEF,
  parameter int FAN_CHANNELS = fsth_pkg::FAN_CHANNELS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // chipset_on, tablet_table, fan_index, temperature, level_index,
  // on_point, off_point, rpm_value
  input  wire logic [fsth_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // func
  input  wire logic [fsth_pkg::S_TUSER_W-1:0] s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // fan_channel, fan_rpm
  output logic      [fsth_pkg::M_TDATA_W-1:0] m_axis_tdata_o
);

  import fsth_pkg::*;

  localparam int LVL_W     = $clog2(LEVELS);
  localparam int PT_DEPTH  = 2 * LEVELS;
  localparam int PT_AW     = $clog2(PT_DEPTH);
  localparam int PT_W      = 2 * TEMP_W;
  localparam int RPM_DEPTH = PT_DEPTH * FAN_CHANNELS;
  localparam int RPM_AW    = $clog2(RPM_DEPTH);
  localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(LEVELS - 1);
  localparam logic [LVL_W-1:0] LVL_ONE = LVL_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_RD,
    ST_DN_CMP,
    ST_RPM_RD,
    ST_EMIT
  } state_e;

  // Input fields.
  func_e                     in_func;
  logic                      in_chip;
  logic                      in_tbl;
  logic                      in_fan;
  logic signed [TEMP_W-1:0]  in_temp;
  logic [LVL_IN_W-1:0]       in_lvl;
  logic signed [TEMP_W-1:0]  in_on;
  logic signed [TEMP_W-1:0]  in_off;
  logic [RPM_W-1:0]          in_rpm;

  assign in_func = func_e'(s_axis_tuser_i[FUNC_BIT]);
  assign in_chip = s_axis_tdata_i[CHIP_BIT];
  assign in_tbl  = s_axis_tdata_i[TBL_BIT];
  assign in_fan  = s_axis_tdata_i[FAN_BIT];
  assign in_temp = s_axis_tdata_i[TEMP_LSB +: TEMP_W];
  assign in_lvl  = s_axis_tdata_i[LVL_LSB +: LVL_IN_W];
  assign in_on   = s_axis_tdata_i[ON_LSB +: TEMP_W];
  assign in_off  = s_axis_tdata_i[OFF_LSB +: TEMP_W];
  assign in_rpm  = s_axis_tdata_i[RPM_LSB +: RPM_W];

  state_e                    state_q;
  logic [LVL_W-1:0]          level_q;
  logic [LVL_W-1:0]          idx_q;
  logic signed [TEMP_W-1:0]  prev_q;
  logic signed [TEMP_W-1:0]  temp_q;
  logic                      tbl_q;
  logic                      fan_q;
  logic                      fan_ok_q;
  logic                      out_valid_q;
  logic                      out_chan_q;
  logic [RPM_W-1:0]          out_rpm_q;

  logic s_acc;
  logic smp_acc;
  logic lvl_ok;
  logic in_fan_ok;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_acc     = s_axis_tvalid_i && s_axis_tready_o;
  assign smp_acc   = s_acc && (in_func == FUNC_SAMPLE) && in_chip;
  assign lvl_ok    = (int'(in_lvl) < LEVELS);
  assign in_fan_ok = (int'(in_fan) < FAN_CHANNELS);

  // Table memories. On point sits in the low half of a points word.
  logic              pt_we;
  logic [PT_AW-1:0]  pt_waddr;
  logic [PT_AW-1:0]  pt_raddr;
  logic [PT_W-1:0]   pt_rdata;
  logic              rpm_we;
  logic [RPM_AW-1:0] rpm_waddr;
  logic [RPM_AW-1:0] rpm_raddr;
  logic [RPM_W-1:0]  rpm_rdata;

  assign pt_we     = s_acc && (in_func == FUNC_WRITE) && lvl_ok;
  assign rpm_we    = pt_we && in_fan_ok;
  assign pt_waddr  = PT_AW'(int'(in_tbl) * LEVELS + int'(in_lvl));
  assign rpm_waddr = RPM_AW'((int'(in_tbl) * LEVELS + int'(in_lvl)) * FAN_CHANNELS
                             + int'(in_fan));
  assign pt_raddr  = PT_AW'(int'(tbl_q) * LEVELS + int'(idx_q));
  assign rpm_raddr = RPM_AW'((int'(tbl_q) * LEVELS + int'(level_q)) * FAN_CHANNELS
                             + int'(fan_q));

  fsth_ram #(
    .WIDTH(PT_W),
    .DEPTH(PT_DEPTH)
  ) u_pt_ram (
    .clk_i   (clk_i),
    .we_i    (pt_we),
    .waddr_i (pt_waddr),
    .wdata_i ({in_off, in_on}),
    .raddr_i (pt_raddr),
    .rdata_o (pt_rdata)
  );

  fsth_ram #(
    .WIDTH(RPM_W),
    .DEPTH(RPM_DEPTH)
  ) u_rpm_ram (
    .clk_i   (clk_i),
    .we_i    (rpm_we),
    .waddr_i (rpm_waddr),
    .wdata_i (in_rpm),
    .raddr_i (rpm_raddr),
    .rdata_o (rpm_rdata)
  );

  // The one comparator: new sample against the stored temperature while
  // idle, then the sample against the point of each visited level.
  logic signed [TEMP_W-1:0] cmp_a;
  logic signed [TEMP_W-1:0] cmp_b;
  cmp_res_t                 cmp_res;

  always_comb begin
    cmp_a = temp_q;
    cmp_b = prev_q;
    case (state_q)
      ST_IDLE: begin
        cmp_a = in_temp;
        cmp_b = prev_q;
      end
      ST_UP_CMP: cmp_b = pt_rdata[TEMP_W-1:0];
      ST_DN_CMP: cmp_b = pt_rdata[PT_W-1:TEMP_W];
      default:   cmp_b = prev_q;
    endcase
  end

  fsth_cmp u_cmp (
    .a_i   (cmp_a),
    .b_i   (cmp_b),
    .res_o (cmp_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      level_q     <= '0;
      idx_q       <= '0;
      prev_q      <= '0;
      temp_q      <= '0;
      tbl_q       <= 1'b0;
      fan_q       <= 1'b0;
      fan_ok_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_chan_q  <= 1'b0;
      out_rpm_q   <= '0;
    end else begin
      // In ST_EMIT the output register is handled by that state alone.
      if (out_valid_q && m_axis_tready_i && (state_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (smp_acc) begin
            temp_q   <= in_temp;
            tbl_q    <= in_tbl;
            fan_q    <= in_fan;
            fan_ok_q <= in_fan_ok;
            prev_q   <= in_temp;
            idx_q    <= level_q;
            if (cmp_res.gt) begin
              state_q <= ST_UP_RD;
            end else if (cmp_res.lt && (level_q != '0)) begin
              state_q <= ST_DN_RD;
            end else begin
              state_q <= ST_RPM_RD;
            end
          end
        end
        ST_UP_RD: state_q <= ST_UP_CMP;
        ST_UP_CMP: begin
          if (!cmp_res.lt) begin
            level_q <= idx_q;
            if (idx_q == LVL_MAX) begin
              state_q <= ST_RPM_RD;
            end else begin
              idx_q   <= idx_q + LVL_ONE;
              state_q <= ST_UP_RD;
            end
          end else begin
            state_q <= ST_RPM_RD;
          end
        end
        ST_DN_RD: state_q <= ST_DN_CMP;
        ST_DN_CMP: begin
          if (!cmp_res.gt) begin
            level_q <= idx_q - LVL_ONE;
            if (idx_q == LVL_ONE) begin
              state_q <= ST_RPM_RD;
            end else begin
              idx_q   <= idx_q - LVL_ONE;
              state_q <= ST_DN_RD;
            end
          end else begin
            state_q <= ST_RPM_RD;
          end
        end
        ST_RPM_RD: state_q <= ST_EMIT;
        ST_EMIT: begin
          // Hold here until the output register is free.
          if (!out_valid_q || m_axis_tready_i) begin
            out_valid_q <= 1'b1;
            out_chan_q  <= fan_q;
            out_rpm_q   <= fan_ok_q ? rpm_rdata : '0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{M_PAD_W{1'b0}}, out_rpm_q, out_chan_q};

endmodule

`default_nettype wire

>>> rtl/core/fsth_ram.sv
// ---------------------------------------------------------------------------
// fsth_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module fsth_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> rtl/core/fsth_cmp.sv
// ---------------------------------------------------------------------------
// fsth_cmp
// Shared signed temperature comparator used by every comparison of a sample.
// ---------------------------------------------------------------------------
`default_nettype none

module fsth_cmp (
  input  wire logic signed [fsth_pkg::TEMP_W-1:0] a_i,
  input  wire logic signed [fsth_pkg::TEMP_W-1:0] b_i,
  output fsth_pkg::cmp_res_t                      res_o
);

  import fsth_pkg::*;

  assign res_o.lt = (a_i < b_i);
  assign res_o.eq = (a_i == b_i);
  assign res_o.gt = (a_i > b_i);

endmodule

`default_nettype wire

>>> rtl/core/fsth_checker.sv
// ---------------------------------------------------------------------------
// fsth_checker
// Port-level assertions for the fan step table block, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fsth_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           s_axis_tvalid_i,
  input wire logic                           s_axis_tready_o,
  input wire logic [fsth_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  input wire logic [fsth_pkg::S_TUSER_W-1:0] s_axis_tuser_i,
  input wire logic                           m_axis_tvalid_o,
  input wire logic                           m_axis_tready_i,
  input wire logic [fsth_pkg::M_TDATA_W-1:0] m_axis_tdata_o
);

  import fsth_pkg::*;

  logic s_acc;
  logic wr_acc;
  logic off_acc;
  logic smp_acc;

  assign s_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign wr_acc  = s_acc && (s_axis_tuser_i[FUNC_BIT] == FUNC_WRITE);
  assign off_acc = s_acc && (s_axis_tuser_i[FUNC_BIT] == FUNC_SAMPLE)
                   && !s_axis_tdata_i[CHIP_BIT];
  assign smp_acc = s_acc && (s_axis_tuser_i[FUNC_BIT] == FUNC_SAMPLE)
                   && s_axis_tdata_i[CHIP_BIT];

  `ASSERT_STABLE_WHEN(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tdata_o, "output data changed while stalled")

  `ASSERT_CLK(a_write_silent, clk_i, rst_ni, (wr_acc && !m_axis_tvalid_o) |=> !m_axis_tvalid_o, "table write produced a result")

  `ASSERT_CLK(a_chip_off_silent, clk_i, rst_ni, (off_acc && !m_axis_tvalid_o) |=> !m_axis_tvalid_o, "sample with chipset off produced a result")

  `ASSERT_CLK(a_sample_busy, clk_i, rst_ni, smp_acc |=> !s_axis_tready_o, "slave side ready right after a sample was taken")

  `ASSERT_CLK(a_result_after_work, clk_i, rst_ni, $rose(m_axis_tvalid_o) |-> !$past(s_axis_tready_o), "result appeared without a sample in progress")

endmodule

bind fan_step_table_hysteresis fsth_checker u_fsth_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
